/* design/nkdt_pkg.sv */
// Package for the name-keyed directory table: request and status codes,
// the stored entry layout and the name normalizing function.
// Depends on nothing; used by the table, the checker and the bench top.
package nkdt_pkg;

  typedef enum logic [2:0] {
    FN_FIND     = 3'd0,
    FN_ADD_FILE = 3'd1,
    FN_ADD_DIR  = 3'd2,
    FN_REMOVE   = 3'd3,
    FN_IS_DIR   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  localparam int NAME_W   = 64;
  localparam int SECTOR_W = 16;
  localparam int INDEX_W  = 4;

  typedef struct packed {
    logic [NAME_W-1:0]   name;
    logic [SECTOR_W-1:0] sector;
    logic                dir;
  } entry_t;

  // Keeps the first nchars bytes up to the first zero byte; the rest reads as zero.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw,
                                                  input int nchars);
    logic [NAME_W-1:0] res;
    logic              stop;
    int                k;
    res  = '0;
    stop = 1'b0;
    for (k = 0; k < NAME_W / 8; k++) begin
      if ((k >= nchars) || (raw[8*k +: 8] == 8'h00)) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*k +: 8] = raw[8*k +: 8];
      end
    end
    return res;
  endfunction

endpackage

/* design/name_keyed_directory_table.sv */
// Name-keyed directory table: sequencer, valid marks and one shared name comparator
// that scans the entry RAM one entry per cycle. Depends on nkdt_pkg and nkdt_ram.
// The scan of the entry RAM ends early when a match is found, and the result strobe is
// registered from the S_DONE state. A new item is taken in the cycle the result is shown.
// The receiver cannot stall. Reset clears all valid marks at once.
module name_keyed_directory_table #(
  parameter int DIR_ENTRIES = 16,
  parameter int NAME_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_name,
  input  logic [15:0] in_sector,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_found_sector,
  output logic [3:0]  out_entry_index,
  output logic        out_is_dir
);

  localparam int IW = $clog2(DIR_ENTRIES);
  localparam int EW = $bits(nkdt_pkg::entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(DIR_ENTRIES - 1);

  nkdt_pkg::state_t  state_r, state_nxt;
  nkdt_pkg::func_t   func_r;
  logic [63:0]       key_r;
  logic [15:0]       sector_r;

  logic [DIR_ENTRIES-1:0] valid_r, valid_nxt;

  logic          issue_r, issue_nxt;
  logic [IW-1:0] issue_idx_r, issue_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r;

  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [15:0]   hit_sec_r, hit_sec_nxt;
  logic          hit_dir_r, hit_dir_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  nkdt_pkg::status_t   status_nxt, status_r;
  logic [15:0]         fsec_nxt, fsec_r;
  logic [3:0]          oidx_nxt, oidx_r;
  logic                odir_nxt, odir_r;

  logic                wr_en;
  nkdt_pkg::entry_t    wr_entry;
  logic [EW-1:0]       rd_bits;
  nkdt_pkg::entry_t    rd_entry;
  logic                name_eq;
  logic [IW+3:0]       hit_idx_ext;
  logic [IW+3:0]       free_idx_ext;

  nkdt_ram #(
    .W(EW),
    .D(DIR_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_entry),
    .rd_en   (issue_r),
    .rd_addr (issue_idx_r),
    .rd_data (rd_bits)
  );

  assign rd_entry     = nkdt_pkg::entry_t'(rd_bits);
  assign name_eq      = valid_r[cmp_idx_r] && (rd_entry.name == key_r);
  assign hit_idx_ext  = {4'b0000, hit_idx_r};
  assign free_idx_ext = {4'b0000, free_idx_r};

  assign wr_entry.name   = key_r;
  assign wr_entry.sector = sector_r;
  assign wr_entry.dir    = (func_r == nkdt_pkg::FN_ADD_DIR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nkdt_pkg::S_IDLE;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == nkdt_pkg::S_IDLE) && start) begin
      func_r   <= nkdt_pkg::func_t'(in_func);
      key_r    <= nkdt_pkg::norm_name(in_name, NAME_CHARS);
      sector_r <= in_sector;
    end
    issue_idx_r <= issue_idx_nxt;
    cmp_idx_r   <= issue_idx_r;
    hit_idx_r   <= hit_idx_nxt;
    hit_sec_r   <= hit_sec_nxt;
    hit_dir_r   <= hit_dir_nxt;
    free_idx_r  <= free_idx_nxt;
    status_r    <= status_nxt;
    fsec_r      <= fsec_nxt;
    oidx_r      <= oidx_nxt;
    odir_r      <= odir_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    issue_nxt     = issue_r;
    issue_idx_nxt = issue_idx_r;
    cmp_vld_nxt   = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_sec_nxt   = hit_sec_r;
    hit_dir_nxt   = hit_dir_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    fsec_nxt      = fsec_r;
    oidx_nxt      = oidx_r;
    odir_nxt      = odir_r;
    wr_en         = 1'b0;

    case (state_r)
      nkdt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt     = nkdt_pkg::S_SCAN;
          issue_nxt     = 1'b1;
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
        end
      end
      nkdt_pkg::S_SCAN: begin
        if (issue_r) begin
          cmp_vld_nxt   = 1'b1;
          issue_idx_nxt = issue_idx_r + 1'b1;
          if (issue_idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end
        end
        if (cmp_vld_r) begin
          if (name_eq) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_sec_nxt = rd_entry.sector;
            hit_dir_nxt = rd_entry.dir;
            issue_nxt   = 1'b0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = nkdt_pkg::S_DONE;
          end else begin
            if (!valid_r[cmp_idx_r] && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              state_nxt = nkdt_pkg::S_DONE;
            end
          end
        end
      end
      nkdt_pkg::S_DONE: begin
        state_nxt     = nkdt_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = nkdt_pkg::ST_NOT_FOUND;
        fsec_nxt      = '0;
        oidx_nxt      = '0;
        odir_nxt      = 1'b0;
        case (func_r)
          nkdt_pkg::FN_FIND, nkdt_pkg::FN_REMOVE, nkdt_pkg::FN_IS_DIR: begin
            if (hit_r) begin
              status_nxt = nkdt_pkg::ST_OK;
              oidx_nxt   = hit_idx_ext[3:0];
              odir_nxt   = hit_dir_r;
              if (func_r == nkdt_pkg::FN_FIND) begin
                fsec_nxt = hit_sec_r;
              end
              if (func_r == nkdt_pkg::FN_REMOVE) begin
                valid_nxt[hit_idx_r] = 1'b0;
              end
            end
          end
          nkdt_pkg::FN_ADD_FILE, nkdt_pkg::FN_ADD_DIR: begin
            if (hit_r) begin
              status_nxt = nkdt_pkg::ST_PRESENT;
            end else if (free_r) begin
              wr_en                 = 1'b1;
              valid_nxt[free_idx_r] = 1'b1;
              status_nxt            = nkdt_pkg::ST_OK;
              oidx_nxt              = free_idx_ext[3:0];
              odir_nxt              = wr_entry.dir;
            end else begin
              status_nxt = nkdt_pkg::ST_FULL;
            end
          end
          default: begin
            status_nxt = nkdt_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      default: begin
        state_nxt = nkdt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != nkdt_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_sector = fsec_r;
  assign out_entry_index  = oidx_r;
  assign out_is_dir       = odir_r;

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == nkdt_pkg::S_DONE))
    else $error("Result strobe without a finished scan.");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the block busy.");

  a_full_means_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == nkdt_pkg::ST_FULL)) |-> (&valid_r))
    else $error("Table full reported with a free entry.");

  a_write_only_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!hit_r && free_r && !valid_r[free_idx_r]))
    else $error("Entry write over a duplicate or a used entry.");

endmodule

/* design/nkdt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module nkdt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* bench/nkdt_dir_checker.sv */
// Checker for the name-keyed directory table: watches the request and result ports,
// keeps its own copy of the directory and compares every result with its prediction.
// Depends on nkdt_pkg for the request and status codes and the field widths.
module nkdt_dir_checker #(
  parameter int DIR_ENTRIES = 16,
  parameter int NAME_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_name,
  input  logic [15:0] in_sector,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_found_sector,
  input  logic [3:0]  out_entry_index,
  input  logic        out_is_dir,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    nkdt_pkg::status_t             status;
    logic [nkdt_pkg::SECTOR_W-1:0] sector;
    logic [nkdt_pkg::INDEX_W-1:0]  index;
    logic                          dir;
  } dir_reply_t;

  logic                          entry_live [DIR_ENTRIES];
  logic [nkdt_pkg::NAME_W-1:0]   entry_key  [DIR_ENTRIES];
  logic [nkdt_pkg::SECTOR_W-1:0] entry_sec  [DIR_ENTRIES];
  logic                          entry_dir  [DIR_ENTRIES];
  dir_reply_t                    reply_q[$];

  function automatic logic [nkdt_pkg::NAME_W-1:0] canonical_name(
      input logic [nkdt_pkg::NAME_W-1:0] raw);
    logic [nkdt_pkg::NAME_W-1:0] key;
    int                          k;
    key = '0;
    for (k = 0; k < NAME_CHARS && k < nkdt_pkg::NAME_W / 8; k++) begin
      if (raw[8*k +: 8] == 8'h00) break;
      key[8*k +: 8] = raw[8*k +: 8];
    end
    return key;
  endfunction

  function automatic dir_reply_t serve_request(input logic [2:0] f,
                                               input logic [nkdt_pkg::NAME_W-1:0] raw,
                                               input logic [nkdt_pkg::SECTOR_W-1:0] sec);
    dir_reply_t                  r;
    logic [nkdt_pkg::NAME_W-1:0] key;
    int                          hit;
    int                          i;
    r = '{status: nkdt_pkg::ST_NOT_FOUND, sector: '0, index: '0, dir: 1'b0};
    key = canonical_name(raw);
    hit = -1;
    for (i = 0; i < DIR_ENTRIES; i++) begin
      if (hit < 0 && entry_live[i] && entry_key[i] == key) hit = i;
    end
    case (f)
      nkdt_pkg::FN_FIND, nkdt_pkg::FN_REMOVE, nkdt_pkg::FN_IS_DIR: begin
        if (hit >= 0) begin
          r.status = nkdt_pkg::ST_OK;
          r.index  = hit[nkdt_pkg::INDEX_W-1:0];
          r.dir    = entry_dir[hit];
          if (f == nkdt_pkg::FN_FIND) r.sector = entry_sec[hit];
          if (f == nkdt_pkg::FN_REMOVE) entry_live[hit] = 1'b0;
        end
      end
      nkdt_pkg::FN_ADD_FILE, nkdt_pkg::FN_ADD_DIR: begin
        if (hit >= 0) begin
          r.status = nkdt_pkg::ST_PRESENT;
        end else begin
          r.status = nkdt_pkg::ST_FULL;
          for (i = 0; i < DIR_ENTRIES; i++) begin
            if (r.status == nkdt_pkg::ST_FULL && !entry_live[i]) begin
              entry_live[i] = 1'b1;
              entry_key[i]  = key;
              entry_sec[i]  = sec;
              entry_dir[i]  = (f == nkdt_pkg::FN_ADD_DIR);
              r.status      = nkdt_pkg::ST_OK;
              r.index       = i[nkdt_pkg::INDEX_W-1:0];
              r.dir         = entry_dir[i];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dir_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < DIR_ENTRIES; i++) entry_live[i] = 1'b0;
      reply_q.delete();
    end else begin
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d index %0d",
                   $time, out_status, out_entry_index);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) report("status", want.status, out_status);
          if (out_found_sector !== want.sector)
            report("found_sector", want.sector, out_found_sector);
          if (out_entry_index !== want.index)
            report("entry_index", want.index, out_entry_index);
          if (out_is_dir !== want.dir) report("is_dir", want.dir, out_is_dir);
        end
      end
      if (start && !busy) reply_q.push_back(serve_request(in_func, in_name, in_sector));
    end
    pending = reply_q.size();
  end

endmodule

/* bench/tb_name_keyed_directory_table.sv */
// Top of the directory table bench: clock, reset, request stimulus and the verdict.
// Depends on nkdt_pkg, the name_keyed_directory_table block and nkdt_dir_checker.
module tb_name_keyed_directory_table ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ENTRIES  = 16;
  localparam int NAME_CHARS   = 8;
  localparam int RANDOM_ITEMS = 1725;
  localparam int CALM_ITEMS   = 150;
  localparam int PHASE_LEN    = 125;
  localparam int POOL_SIZE    = 24;
  localparam int UNUSED_CODES = 3;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic [2:0]  in_func   = '0;
  logic [63:0] in_name   = '0;
  logic [15:0] in_sector = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_found_sector;
  logic [3:0]  out_entry_index;
  logic        out_is_dir;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  logic [63:0] name_pool [POOL_SIZE];
  int          name_len  [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** name_keyed_directory_table: FAILED **");
      $finish;
    end
  end

  name_keyed_directory_table #(
    .DIR_ENTRIES(DIR_ENTRIES),
    .NAME_CHARS (NAME_CHARS)
  ) dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_name, .in_sector,
    .out_valid, .out_status, .out_found_sector, .out_entry_index, .out_is_dir
  );

  nkdt_dir_checker #(
    .DIR_ENTRIES(DIR_ENTRIES),
    .NAME_CHARS (NAME_CHARS)
  ) u_checker (
    .clk, .rst_n, .start, .busy, .in_func, .in_name, .in_sector,
    .out_valid, .out_status, .out_found_sector, .out_entry_index, .out_is_dir,
    .fail_count, .pending
  );

  task automatic send_request(input logic [2:0] f, input logic [63:0] nm,
                              input logic [15:0] sec, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    in_func   <= f;
    in_name   <= nm;
    in_sector <= sec;
    do @(posedge clk); while (busy);
  endtask

  // A name from the pool, sometimes with junk after its terminating zero byte.
  function automatic logic [63:0] pool_name();
    int          p;
    int          k;
    logic [63:0] nm;
    p  = $urandom_range(0, POOL_SIZE - 1);
    nm = name_pool[p];
    if (name_len[p] < 8 && $urandom_range(0, 1) == 1) begin
      for (k = name_len[p] + 1; k < 8; k++) nm[8*k +: 8] = 8'($urandom);
    end
    return nm;
  endfunction

  initial begin
    int          n;
    int          k;
    int          gap;
    int          pick;
    int          add_pct;
    int          rem_pct;
    logic [2:0]  f;
    logic [63:0] nm;

    for (n = 0; n < POOL_SIZE; n++) begin
      name_len[n] = $urandom_range(1, 8);
      nm = '0;
      for (k = 0; k < name_len[n]; k++) nm[8*k +: 8] = 8'($urandom_range(1, 255));
      name_pool[n] = nm;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(nkdt_pkg::FN_FIND, 64'h61, 16'h0000, 0);
    send_request(nkdt_pkg::FN_REMOVE, 64'h61, 16'hFFFF, 0);
    send_request(nkdt_pkg::FN_ADD_FILE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0);
    send_request(nkdt_pkg::FN_ADD_DIR, 64'hFFFF_FFFF_FFFF_0061, 16'h0000, 1);
    send_request(nkdt_pkg::FN_FIND, 64'h0000_0000_0000_0061, 16'h0000, 0);
    send_request(nkdt_pkg::FN_ADD_FILE, 64'h0000_0000_0000_0061, 16'h5A5A, 0);
    send_request(nkdt_pkg::FN_ADD_FILE, 64'h0000_0000_0000_0000, 16'h1234, 3);
    send_request(nkdt_pkg::FN_IS_DIR, 64'h0000_0000_0000_0061, 16'h0000, 0);
    send_request(nkdt_pkg::FN_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 0);
    send_request(3'(nkdt_pkg::FN_IS_DIR + 1), 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0);
    send_request(3'(nkdt_pkg::FN_IS_DIR + UNUSED_CODES), 64'h61, 16'h0000, 2);
    for (k = 0; k < DIR_ENTRIES - 2; k++) begin
      send_request((k % 2 == 0) ? nkdt_pkg::FN_ADD_FILE : nkdt_pkg::FN_ADD_DIR,
                   {48'h0, 8'(8'h30 + k), 8'h66}, 16'(k * 4097), 0);
    end
    send_request(nkdt_pkg::FN_ADD_DIR, 64'h7A7A, 16'hBEEF, 0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate phases that fill the table and phases that drain it.
      add_pct = ((n / PHASE_LEN) % 2 == 0) ? 50 : 20;
      rem_pct = ((n / PHASE_LEN) % 2 == 0) ? 15 : 40;
      pick = $urandom_range(0, 99);
      if (pick < 3) f = 3'(nkdt_pkg::FN_IS_DIR + 1 + $urandom_range(0, UNUSED_CODES - 1));
      else if (pick < 3 + add_pct)
        f = ($urandom_range(0, 1) == 1) ? nkdt_pkg::FN_ADD_DIR : nkdt_pkg::FN_ADD_FILE;
      else if (pick < 3 + add_pct + rem_pct) f = nkdt_pkg::FN_REMOVE;
      else f = ($urandom_range(0, 1) == 1) ? nkdt_pkg::FN_IS_DIR : nkdt_pkg::FN_FIND;

      pick = $urandom_range(0, 99);
      if (pick < 85) nm = pool_name();
      else if (pick < 95) nm = {$urandom, $urandom};
      else if (pick < 98) nm = {$urandom, $urandom} & ~64'hFF;
      else nm = '0;

      if (n >= RANDOM_ITEMS - CALM_ITEMS || $urandom_range(0, 3) != 0) gap = 0;
      else gap = $urandom_range(1, 7);

      send_request(f, nm, 16'($urandom_range(0, 65535)), gap);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DIR_ENTRIES + 8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** name_keyed_directory_table: PASSED **");
    end else begin
      $display("** name_keyed_directory_table: FAILED **");
    end
    $finish;
  end

endmodule
